### src/hcm_pkg.sv
// Shared types and codes of the hue color map.
// No dependencies; imported by every module of the block.
`default_nettype none

package hcm_pkg;

   // register indexes of the configuration port
   localparam logic [2:0] REG_VALUE_BEGIN = 3'd0;
   localparam logic [2:0] REG_VALUE_END   = 3'd1;
   localparam logic [2:0] REG_HUE_BEGIN   = 3'd2;
   localparam logic [2:0] REG_HUE_END     = 3'd3;
   localparam logic [2:0] REG_SATURATION  = 3'd4;
   localparam logic [2:0] REG_LIGHTNESS   = 3'd5;

   // how the hue of a beat is formed
   typedef enum logic [1:0] {
      MODE_BEGIN,
      MODE_END,
      MODE_INTERP
   } hue_mode_type;

   // which segment of the channel curve a component falls on
   typedef enum logic [1:0] {
      KIND_RISE,
      KIND_HIGH,
      KIND_FALL,
      KIND_LOW
   } chan_kind_type;

   // pipeline control from the top level
   typedef struct packed {
      logic advance;
      logic in_valid;
   } pipe_ctl_type;

endpackage

`default_nettype wire

### src/hcm_csr.sv
// Configuration registers with APB-style access, and the HSL p/q terms.
// Depends on hcm_pkg.
`default_nettype none

module hcm_csr
   import hcm_pkg::*;
#(
   parameter int SAMPLE_WIDTH = 32,
   parameter int COLOR_WIDTH  = 16,
   parameter int DATA_WIDTH   = 32,
   parameter int ADDR_SHIFT   = 2,
   parameter int ADDR_WIDTH   = 5
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    csr_psel,
   input  wire logic                    csr_penable,
   input  wire logic                    csr_pwrite,
   input  wire logic [ADDR_WIDTH-1:0]   csr_paddr,
   input  wire logic [DATA_WIDTH-1:0]   csr_pwdata,
   output logic      [DATA_WIDTH-1:0]   csr_prdata,
   output logic                         csr_pready,
   output logic      [SAMPLE_WIDTH-1:0] value_begin,
   output logic      [SAMPLE_WIDTH-1:0] value_end,
   output logic      [COLOR_WIDTH-1:0]  hue_begin,
   output logic      [COLOR_WIDTH-1:0]  hue_end,
   output logic      [COLOR_WIDTH:0]    level_p,
   output logic      [COLOR_WIDTH:0]    level_q
);

   localparam int CW = COLOR_WIDTH;
   localparam logic [CW-1:0] HUE_END_RST = CW'((64'd2 << CW) / 64'd3);
   localparam logic [CW-1:0] LIGHT_RST   = {1'b1, {(CW-1){1'b0}}};

   logic [SAMPLE_WIDTH-1:0] vbeg_ff, vend_ff;
   logic [CW-1:0]           hbeg_ff, hend_ff, sat_ff, light_ff;
   logic [CW:0]             p_ff, q_ff, p_in, q_in;
   logic [2*CW-1:0]         ls_full;
   logic [CW:0]             ls, l2;
   logic [2:0]              index;
   logic                    wr;

   assign index      = csr_paddr[ADDR_WIDTH-1:ADDR_SHIFT];
   assign wr         = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         vbeg_ff  <= '0;
         vend_ff  <= '0;
         hbeg_ff  <= '0;
         hend_ff  <= HUE_END_RST;
         sat_ff   <= '1;
         light_ff <= LIGHT_RST;
      end else if (wr) begin
         case (index)
            REG_VALUE_BEGIN: vbeg_ff  <= csr_pwdata[SAMPLE_WIDTH-1:0];
            REG_VALUE_END:   vend_ff  <= csr_pwdata[SAMPLE_WIDTH-1:0];
            REG_HUE_BEGIN:   hbeg_ff  <= csr_pwdata[CW-1:0];
            REG_HUE_END:     hend_ff  <= csr_pwdata[CW-1:0];
            REG_SATURATION:  sat_ff   <= csr_pwdata[CW-1:0];
            REG_LIGHTNESS:   light_ff <= csr_pwdata[CW-1:0];
            default: ;
         endcase
      end
   end

   // read mux
   always_comb begin
      case (index)
         REG_VALUE_BEGIN: csr_prdata = DATA_WIDTH'(vbeg_ff);
         REG_VALUE_END:   csr_prdata = DATA_WIDTH'(vend_ff);
         REG_HUE_BEGIN:   csr_prdata = DATA_WIDTH'(hbeg_ff);
         REG_HUE_END:     csr_prdata = DATA_WIDTH'(hend_ff);
         REG_SATURATION:  csr_prdata = DATA_WIDTH'(sat_ff);
         REG_LIGHTNESS:   csr_prdata = DATA_WIDTH'(light_ff);
         default:         csr_prdata = '0;
      endcase
   end

   // q = l + l*s or l + s - l*s, p = max(0, 2l - q)
   always_comb begin
      ls_full = light_ff * sat_ff;
      ls      = {1'b0, ls_full[2*CW-1:CW]};
      if (!light_ff[CW-1])
         q_in = {1'b0, light_ff} + ls;
      else
         q_in = {1'b0, light_ff} + {1'b0, sat_ff} - ls;
      l2   = {light_ff, 1'b0};
      p_in = (l2 > q_in) ? l2 - q_in : '0;
   end

   // p/q are registered from the lightness and saturation registers, long before a beat needs them
   always_ff @(posedge clock) begin
      p_ff <= p_in;
      q_ff <= q_in;
   end

   assign value_begin = vbeg_ff;
   assign value_end   = vend_ff;
   assign hue_begin   = hbeg_ff;
   assign hue_end     = hend_ff;
   assign level_p     = p_ff;
   assign level_q     = q_ff;

endmodule

`default_nettype wire

### src/hcm_hue.sv
// Hue pipeline: range check, bit-serial fraction divider, hue interpolation.
// Depends on hcm_pkg.
`default_nettype none

module hcm_hue
   import hcm_pkg::*;
#(
   parameter int SAMPLE_WIDTH = 32,
   parameter int COLOR_WIDTH  = 16
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire pipe_ctl_type            ctl,
   input  wire logic [SAMPLE_WIDTH-1:0] sample_value,
   input  wire logic [SAMPLE_WIDTH-1:0] value_begin,
   input  wire logic [SAMPLE_WIDTH-1:0] value_end,
   input  wire logic [COLOR_WIDTH-1:0]  hue_begin,
   input  wire logic [COLOR_WIDTH-1:0]  hue_end,
   output logic                         hue_valid,
   output logic      [COLOR_WIDTH-1:0]  hue_value
);

   localparam int SW = SAMPLE_WIDTH;
   localparam int CW = COLOR_WIDTH;
   localparam logic [SW-1:0] SIGN_BIT = {1'b1, {(SW-1){1'b0}}};

   logic [SW-1:0]  rem_ff  [CW+1];
   logic [SW-1:0]  den_ff  [CW+1];
   logic [CW-1:0]  frac_ff [CW+1];
   hue_mode_type   mode_ff [CW+1];
   logic           vld_ff  [CW+1];

   logic [SW-1:0]  kv, kb, ke, num, den;
   logic           kv_gt, ke_gt;
   hue_mode_type   mode_in;

   // range check on order-preserving keys
   always_comb begin
      kv    = sample_value ^ SIGN_BIT;
      kb    = value_begin ^ SIGN_BIT;
      ke    = value_end ^ SIGN_BIT;
      kv_gt = kv > kb;
      ke_gt = ke > kb;
      num   = kv_gt ? kv - kb : kb - kv;
      den   = ke_gt ? ke - kb : kb - ke;
      if (hue_begin >= hue_end || kb == ke || kv == kb || kv_gt != ke_gt)
         mode_in = MODE_BEGIN;
      else if (num >= den)
         mode_in = MODE_END;
      else
         mode_in = MODE_INTERP;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else if (ctl.advance) begin
         vld_ff[0] <= ctl.in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.advance) begin
         rem_ff[0]  <= num;
         den_ff[0]  <= den;
         frac_ff[0] <= '0;
         mode_ff[0] <= mode_in;
      end
   end

   // one quotient bit per stage
   for (genvar k = 0; k < CW; k++) begin : g_div
      logic [SW:0] shifted, diff;
      logic        ge;

      always_comb begin
         shifted = {rem_ff[k], 1'b0};
         ge      = shifted >= {1'b0, den_ff[k]};
         diff    = shifted - {1'b0, den_ff[k]};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k+1] <= 1'b0;
         end else if (ctl.advance) begin
            vld_ff[k+1] <= vld_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (ctl.advance) begin
            rem_ff[k+1]  <= ge ? diff[SW-1:0] : shifted[SW-1:0];
            den_ff[k+1]  <= den_ff[k];
            frac_ff[k+1] <= {frac_ff[k][CW-2:0], ge};
            mode_ff[k+1] <= mode_ff[k];
         end
      end
   end

   // fraction times hue span, then offset by the begin hue
   logic [2*CW-1:0] prod_ff;
   hue_mode_type    mmode_ff;
   logic            mvld_ff;
   logic [CW-1:0]   span, hue_in;
   logic [CW-1:0]   hue_ff;
   logic            hvld_ff;

   assign span = hue_end - hue_begin;

   always_comb begin
      case (mmode_ff)
         MODE_BEGIN:  hue_in = hue_begin;
         MODE_END:    hue_in = hue_end;
         MODE_INTERP: hue_in = hue_begin + prod_ff[2*CW-1:CW];
         default:     hue_in = hue_begin;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mvld_ff <= 1'b0;
         hvld_ff <= 1'b0;
      end else if (ctl.advance) begin
         mvld_ff <= vld_ff[CW];
         hvld_ff <= mvld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.advance) begin
         prod_ff  <= frac_ff[CW] * span;
         mmode_ff <= mode_ff[CW];
         hue_ff   <= hue_in;
      end
   end

   assign hue_valid = hvld_ff;
   assign hue_value = hue_ff;

endmodule

`default_nettype wire

### src/hcm_rgb.sv
// HSL-to-RGB pipeline: segment select, scaling multiply, offset and clamp.
// Depends on hcm_pkg.
`default_nettype none

module hcm_rgb
   import hcm_pkg::*;
#(
   parameter int COLOR_WIDTH = 16
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   advance,
   input  wire logic                   hue_valid,
   input  wire logic [COLOR_WIDTH-1:0] hue_value,
   input  wire logic [COLOR_WIDTH:0]   level_p,
   input  wire logic [COLOR_WIDTH:0]   level_q,
   output logic                        out_valid,
   output logic      [COLOR_WIDTH-1:0] red_level,
   output logic      [COLOR_WIDTH-1:0] green_level,
   output logic      [COLOR_WIDTH-1:0] blue_level
);

   localparam int CW = COLOR_WIDTH;
   localparam int TW = CW + 4;
   localparam logic [TW-1:0] ONE  = TW'(1) << CW;
   localparam logic [TW-1:0] SIX  = ONE * TW'(6);
   localparam logic [CW:0]   CMAX = {1'b0, {CW{1'b1}}};

   logic [TW-1:0]   t_hue;
   logic [TW-1:0]   t_ch   [3];
   chan_kind_type   kind_in [3];
   logic [CW:0]     x_in   [3];
   chan_kind_type   kind_ff [3];
   logic [CW:0]     x_ff   [3];
   chan_kind_type   kind2_ff [3];
   logic [2*CW+1:0] prod_ff [3];
   logic [CW-1:0]   col_ff [3];
   logic [CW:0]     span;
   logic            v1_ff, v2_ff, v3_ff;

   assign span = level_q - level_p;

   // hue in sixths, red leads by a third of a turn and blue trails
   always_comb begin
      logic [TW-1:0] tr, tb;
      t_hue = (TW'(hue_value) << 2) + (TW'(hue_value) << 1);
      tr    = t_hue + (ONE << 1);
      tb    = t_hue + (ONE << 2);
      t_ch[0] = (tr >= SIX) ? tr - SIX : tr;
      t_ch[1] = t_hue;
      t_ch[2] = (tb >= SIX) ? tb - SIX : tb;
   end

   // segment of the curve and the scaling term
   for (genvar c = 0; c < 3; c++) begin : g_sel
      always_comb begin
         logic [TW-1:0] fall;
         fall = (ONE << 2) - t_ch[c];
         if (t_ch[c] < ONE) begin
            kind_in[c] = KIND_RISE;
            x_in[c]    = t_ch[c][CW:0];
         end else if (t_ch[c] < ONE * TW'(3)) begin
            kind_in[c] = KIND_HIGH;
            x_in[c]    = '0;
         end else if (t_ch[c] < (ONE << 2)) begin
            kind_in[c] = KIND_FALL;
            x_in[c]    = fall[CW:0];
         end else begin
            kind_in[c] = KIND_LOW;
            x_in[c]    = '0;
         end
      end

      logic [CW+1:0] sum;

      always_comb begin
         case (kind2_ff[c])
            KIND_RISE, KIND_FALL:
               sum = {1'b0, level_p} + {1'b0, prod_ff[c][2*CW:CW]};
            KIND_HIGH: sum = {1'b0, level_q};
            KIND_LOW:  sum = {1'b0, level_p};
            default:   sum = {1'b0, level_p};
         endcase
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            kind_ff[c]  <= kind_in[c];
            x_ff[c]     <= x_in[c];
            kind2_ff[c] <= kind_ff[c];
            prod_ff[c]  <= span * x_ff[c];
            col_ff[c]   <= (sum > {1'b0, CMAX}) ? CMAX[CW-1:0] : sum[CW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (advance) begin
         v1_ff <= hue_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   assign out_valid   = v3_ff;
   assign red_level   = col_ff[0];
   assign green_level = col_ff[1];
   assign blue_level  = col_ff[2];

endmodule

`default_nettype wire

### src/hue_colormap_hsl_to_rgb.sv
// Top level of the hue color map: stream ports, configuration port, pipeline.
// Depends on hcm_pkg, hcm_csr, hcm_hue and hcm_rgb.
`default_nettype none

// Maps one signed Q16.16 sample per beat to an RGB color. The sample is placed
// in the configured value range, a hue is interpolated between the begin and
// end hues and clamped to them, and the hue with the configured saturation and
// lightness is converted from HSL to RGB. One beat is accepted per cycle while
// the output is not blocked. The divider is bit-serial, one quotient bit per
// stage. The whole pipeline holds while a result waits on rsp_tready. Registers:
// 0 value_begin, 1 value_end, 2 hue_begin, 3 hue_end, 4 saturation_level,
// 5 lightness_level, at 4*i (8*i when SAMPLE_WIDTH exceeds 32); write them
// only while the block is idle.
module hue_colormap_hsl_to_rgb
   import hcm_pkg::*;
#(
   parameter int SAMPLE_WIDTH = 32,
   parameter int COLOR_WIDTH  = 16
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // req_tdata: sample_value
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [((SAMPLE_WIDTH+7)/8)*8-1:0]  req_tdata,
   // rsp_tdata: red_level, green_level, blue_level
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [((3*COLOR_WIDTH+7)/8)*8-1:0]      rsp_tdata,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [((SAMPLE_WIDTH > 32) ? 3 : 2)+2:0] csr_paddr,
   input  wire logic [((SAMPLE_WIDTH > 32) ? 64 : 32)-1:0] csr_pwdata,
   output logic      [((SAMPLE_WIDTH > 32) ? 64 : 32)-1:0] csr_prdata,
   output logic                       csr_pready
);

   localparam int CW         = COLOR_WIDTH;
   localparam int OUT_W      = ((3*CW+7)/8)*8;
   localparam int ADDR_SHIFT = (SAMPLE_WIDTH > 32) ? 3 : 2;
   localparam int DATA_W     = (SAMPLE_WIDTH > 32) ? 64 : 32;

   logic [SAMPLE_WIDTH-1:0] value_begin, value_end;
   logic [CW-1:0]           hue_begin, hue_end, hue_value;
   logic [CW:0]             level_p, level_q;
   logic [CW-1:0]           red, green, blue;
   logic                    hue_valid, advance;
   pipe_ctl_type            ctl;

   // the pipeline moves whenever the output register is free or drains
   assign advance     = !rsp_tvalid || rsp_tready;
   assign req_tready  = advance;
   assign ctl.advance  = advance;
   assign ctl.in_valid = req_tvalid;

   hcm_csr #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH),
      .COLOR_WIDTH  (CW),
      .DATA_WIDTH   (DATA_W),
      .ADDR_SHIFT   (ADDR_SHIFT),
      .ADDR_WIDTH   (ADDR_SHIFT + 3)
   ) u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .value_begin (value_begin),
      .value_end   (value_end),
      .hue_begin   (hue_begin),
      .hue_end     (hue_end),
      .level_p     (level_p),
      .level_q     (level_q)
   );

   hcm_hue #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH),
      .COLOR_WIDTH  (CW)
   ) u_hue (
      .clock        (clock),
      .reset        (reset),
      .ctl          (ctl),
      .sample_value (req_tdata[SAMPLE_WIDTH-1:0]),
      .value_begin  (value_begin),
      .value_end    (value_end),
      .hue_begin    (hue_begin),
      .hue_end      (hue_end),
      .hue_valid    (hue_valid),
      .hue_value    (hue_value)
   );

   hcm_rgb #(
      .COLOR_WIDTH (CW)
   ) u_rgb (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .hue_valid   (hue_valid),
      .hue_value   (hue_value),
      .level_p     (level_p),
      .level_q     (level_q),
      .out_valid   (rsp_tvalid),
      .red_level   (red),
      .green_level (green),
      .blue_level  (blue)
   );

   assign rsp_tdata = OUT_W'({blue, green, red});

`ifndef SYNTH
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid right after reset");
   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(hue_valid) && $stable(hue_value))
      else $error("hue stage moved during a stall");
   a_q_not_below_p: assert property (@(posedge clock) disable iff (reset)
      !$rose(csr_psel) |-> level_q >= level_p)
      else $error("HSL q term below p term");
   a_ready_follows_output: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |-> !req_tready)
      else $error("input taken while the output is blocked");
`endif

endmodule

`default_nettype wire
